[hw/rtl/nor_program_erase_sequencer_core_defines.svh]
// Assertion macros shared by the checker.
// Each macro takes a label, a clock, a disable condition, an antecedent and a consequent.
`ifndef NOR_PROGRAM_ERASE_SEQUENCER_CORE_DEFINES_SVH
`define NOR_PROGRAM_ERASE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define NPES_CHECK_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("npes check failed");

// next-cycle implication
`define NPES_CHECK_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("npes check failed");

`endif

[hw/rtl/npes_pkg.sv]
// ----------------------------------------------------------------------------
// npes_pkg
// Types, codes and constants of the NOR program/erase command sequencer.
// ----------------------------------------------------------------------------
package npes_pkg;

    localparam int ADDRESS_BITS = 22;
    localparam int SECTOR_BITS  = 16;

    localparam int ADDR_W  = 22;
    localparam int DATA_W  = 16;
    localparam int RD_W    = 32;
    localparam int LIMIT_W = 18;
    localparam int STEP_W  = 3;

    localparam int ADDR_KEEP = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK   = ADDR_W'((64'd1 << ADDR_KEEP) - 64'd1);
    localparam logic [ADDR_W-1:0] SECTOR_MASK = ~ADDR_W'((64'd1 << SECTOR_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] WORD_MASK   = ~ADDR_W'(3);

    localparam logic [LIMIT_W-1:0] PROG_LIMIT_RST  = LIMIT_W'(10000);
    localparam logic [LIMIT_W-1:0] ERASE_LIMIT_RST = LIMIT_W'(200000);

    // job queue between front and back
    localparam int JOB_DEPTH = 4;
    localparam int JOB_AW    = 2;

    // input actions
    localparam logic [1:0] ACT_PROGRAM  = 2'd0;
    localparam logic [1:0] ACT_ERASE    = 2'd1;
    localparam logic [1:0] ACT_RESPONSE = 2'd2;

    // result kinds
    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_DONE    = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_REJECT  = 3'd4;

    // job kinds
    localparam logic [2:0] JOB_PROG    = 3'd0;
    localparam logic [2:0] JOB_ERASE   = 3'd1;
    localparam logic [2:0] JOB_READ    = 3'd2;
    localparam logic [2:0] JOB_DONE    = 3'd3;
    localparam logic [2:0] JOB_TIMEOUT = 3'd4;
    localparam logic [2:0] JOB_REJECT  = 3'd5;

    // phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PROG  = 2'd1;
    localparam logic [1:0] PH_ERASE = 2'd2;

    // unlock cycle constants
    localparam logic [ADDR_W-1:0] UNLOCK_A1 = ADDR_W'(32'h0000_5555);
    localparam logic [ADDR_W-1:0] UNLOCK_A2 = ADDR_W'(32'h0000_2AAA);
    localparam logic [DATA_W-1:0] UNLOCK_D1 = 16'hAAAA;
    localparam logic [DATA_W-1:0] UNLOCK_D2 = 16'h5555;
    localparam logic [DATA_W-1:0] CMD_PROG  = 16'hA0A0;
    localparam logic [DATA_W-1:0] CMD_ERASE = 16'h8080;
    localparam logic [DATA_W-1:0] CMD_SECT  = 16'h3030;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] target_address;
        logic [DATA_W-1:0] program_data;
        logic [RD_W-1:0]   read_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        op_kind;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] bus_data;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_job;

endpackage

[hw/rtl/npes_front.sv]
// ----------------------------------------------------------------------------
// npes_front
// Accepts commands and responses, keeps the polling state and turns each
// transaction into one job for the back end.
// ----------------------------------------------------------------------------
module npes_front import npes_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [LIMIT_W-1:0]  i_cfg_wdata,
    output t_job                o_job
);

    logic [1:0]         r_phase, n_phase;
    logic [ADDR_W-1:0]  r_saved_address, n_saved_address;
    logic [DATA_W-1:0]  r_saved_word, n_saved_word;
    logic [LIMIT_W-1:0] r_polls_left, n_polls_left;
    logic [LIMIT_W-1:0] r_prog_limit, r_erase_limit;

    logic              busy;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] sector;
    logic [DATA_W-1:0] half;
    logic              ok;

    function automatic logic [LIMIT_W-1:0] first_budget(input logic [LIMIT_W-1:0] lim);
        first_budget = (lim == '0) ? '0 : lim - LIMIT_W'(1);
    endfunction

    assign busy   = (r_phase == PH_PROG) || (r_phase == PH_ERASE);
    assign addr   = i_item.target_address & ADDR_MASK;
    assign sector = addr & SECTOR_MASK;
    assign half   = r_saved_address[1] ? i_item.read_data[31:16] : i_item.read_data[15:0];

    always_comb begin
        n_phase         = r_phase;
        n_saved_address = r_saved_address;
        n_saved_word    = r_saved_word;
        n_polls_left    = r_polls_left;
        o_job           = '{kind: JOB_REJECT, addr: '0, data: '0};
        ok              = 1'b0;
        unique case (i_item.action)
            ACT_PROGRAM: begin
                if (!busy) begin
                    o_job           = '{kind: JOB_PROG, addr: addr, data: i_item.program_data};
                    n_phase         = PH_PROG;
                    n_saved_address = addr;
                    n_saved_word    = i_item.program_data;
                    n_polls_left    = first_budget(r_prog_limit);
                end
            end
            ACT_ERASE: begin
                if (!busy) begin
                    o_job           = '{kind: JOB_ERASE, addr: sector, data: '0};
                    n_phase         = PH_ERASE;
                    n_saved_address = sector;
                    n_saved_word    = '0;
                    n_polls_left    = first_budget(r_erase_limit);
                end
            end
            ACT_RESPONSE: begin
                if (busy) begin
                    if (r_phase == PH_PROG) begin
                        ok = (half == r_saved_word);
                    end else begin
                        ok = i_item.read_data[7] && i_item.read_data[23];
                    end
                    if (ok) begin
                        o_job.kind = JOB_DONE;
                        n_phase    = PH_IDLE;
                    end else if (r_polls_left == '0) begin
                        o_job.kind = JOB_TIMEOUT;
                        n_phase    = PH_IDLE;
                    end else begin
                        o_job.kind   = JOB_READ;
                        o_job.addr   = (r_phase == PH_PROG) ? (r_saved_address & WORD_MASK)
                                                            : r_saved_address;
                        n_polls_left = r_polls_left - LIMIT_W'(1);
                    end
                end
            end
            default: begin
                o_job.kind = JOB_REJECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_saved_address <= '0;
            r_saved_word    <= '0;
            r_polls_left    <= '0;
            r_prog_limit    <= PROG_LIMIT_RST;
            r_erase_limit   <= ERASE_LIMIT_RST;
        end else begin
            if (i_accept) begin
                r_phase         <= n_phase;
                r_saved_address <= n_saved_address;
                r_saved_word    <= n_saved_word;
                r_polls_left    <= n_polls_left;
            end
            if (i_cfg_we) begin
                if (i_cfg_index) begin
                    r_erase_limit <= i_cfg_wdata;
                end else begin
                    r_prog_limit <= i_cfg_wdata;
                end
            end
        end
    end

endmodule

[hw/rtl/npes_job_fifo.sv]
// ----------------------------------------------------------------------------
// npes_job_fifo
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module npes_job_fifo import npes_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_mem [JOB_DEPTH];
    logic [JOB_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [JOB_AW:0]   r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (JOB_AW+1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + JOB_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + JOB_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (JOB_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (JOB_AW+1)'(1);
            end
        end
    end

endmodule

[hw/rtl/npes_back.sv]
// ----------------------------------------------------------------------------
// npes_back
// Expands the job at the queue head into bus cycles and status results,
// one result per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module npes_back import npes_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_empty,
    output logic      o_job_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         item;
    logic              advance, emit;

    assign advance = !r_out_valid || i_pop;
    assign emit    = advance && !i_job_empty;

    always_comb begin
        item = '{op_kind: OP_REJECT, bus_address: '0, bus_data: '0, last: 1'b1};
        unique case (i_job.kind)
            JOB_PROG: begin
                item.last    = 1'b0;
                item.op_kind = OP_WRITE;
                case (r_step)
                    3'd0:    begin item.bus_address = UNLOCK_A1; item.bus_data = UNLOCK_D1; end
                    3'd1:    begin item.bus_address = UNLOCK_A2; item.bus_data = UNLOCK_D2; end
                    3'd2:    begin item.bus_address = UNLOCK_A1; item.bus_data = CMD_PROG;  end
                    3'd3:    begin item.bus_address = i_job.addr; item.bus_data = i_job.data; end
                    default: begin
                        item.op_kind     = OP_READ;
                        item.bus_address = i_job.addr & WORD_MASK;
                        item.last        = 1'b1;
                    end
                endcase
            end
            JOB_ERASE: begin
                item.last    = 1'b0;
                item.op_kind = OP_WRITE;
                case (r_step)
                    3'd0:    begin item.bus_address = UNLOCK_A1; item.bus_data = UNLOCK_D1; end
                    3'd1:    begin item.bus_address = UNLOCK_A2; item.bus_data = UNLOCK_D2; end
                    3'd2:    begin item.bus_address = UNLOCK_A1; item.bus_data = CMD_ERASE; end
                    3'd3:    begin item.bus_address = UNLOCK_A1; item.bus_data = UNLOCK_D1; end
                    3'd4:    begin item.bus_address = UNLOCK_A2; item.bus_data = UNLOCK_D2; end
                    3'd5:    begin item.bus_address = i_job.addr; item.bus_data = CMD_SECT; end
                    default: begin
                        item.op_kind     = OP_READ;
                        item.bus_address = i_job.addr;
                        item.last        = 1'b1;
                    end
                endcase
            end
            JOB_READ: begin
                item.op_kind     = OP_READ;
                item.bus_address = i_job.addr;
            end
            JOB_DONE:    item.op_kind = OP_DONE;
            JOB_TIMEOUT: item.op_kind = OP_TIMEOUT;
            default:     item.op_kind = OP_REJECT;
        endcase
    end

    assign o_job_pop = emit && item.last;
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= !i_job_empty;
            end
            if (emit) begin
                r_step <= item.last ? '0 : r_step + STEP_W'(1);
            end
        end
    end

endmodule

[hw/rtl/nor_program_erase_sequencer_core.sv]
// ----------------------------------------------------------------------------
// nor_program_erase_sequencer_core
// AMD-style NOR program/erase command sequencer with completion polling.
// ----------------------------------------------------------------------------
// Input queue: push/full. Program, erase and read-response transactions enter
// through i_in_item; one is taken per cycle while full is low.
// Result queue: empty/pop. Each transaction yields 1 to 7 results (bus writes,
// bus reads, done, timeout or rejected); the final one carries last.
// With the back end idle, a taken transaction's first result passes the job
// queue and output register. The back end issues one result per cycle while
// its output is empty or popped; a program gives 5, an erase 7, a response 1.
// The front takes one per cycle; a 4-entry job queue absorbs the difference.
// Poll limits are written through i_cfg_* (index 0 program, 1 erase); the user
// writes them only while the block is idle, which the block does not enforce.
// Reset: synchronous, active low; clears the phase, the job queue and the
// output valid flag and restores the poll limits to 10000 and 200000.
// When pop stays low the current result holds; the job queue fills and full
// rises once four jobs are waiting, counting the one being expanded.
// ----------------------------------------------------------------------------
module nor_program_erase_sequencer_core import npes_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  t_in_item           i_in_item,
    output logic               empty,
    input  logic               pop,
    output t_out_item          o_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_wdata
);

    t_job front_job, head_job;
    logic accept, job_empty, job_pop;

    assign accept = push && !full;

    npes_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_job       (front_job)
    );

    npes_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_job   (head_job),
        .o_empty (job_empty)
    );

    npes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

[hw/rtl/npes_checker.sv]
// ----------------------------------------------------------------------------
// npes_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "nor_program_erase_sequencer_core_defines.svh"

module npes_checker import npes_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_pop,
    input logic      i_empty,
    input t_out_item i_out_item
);

    logic is_status;
    logic status_clear;
    logic is_read;
    logic read_clean;
    logic stalled;

    assign is_status    = !i_empty && (i_out_item.op_kind == OP_DONE ||
                                       i_out_item.op_kind == OP_TIMEOUT ||
                                       i_out_item.op_kind == OP_REJECT);
    assign status_clear = i_out_item.last && i_out_item.bus_address == '0 &&
                          i_out_item.bus_data == '0;
    assign is_read      = !i_empty && i_out_item.op_kind == OP_READ;
    assign read_clean   = i_out_item.bus_address[1:0] == 2'b00 && i_out_item.bus_data == '0;
    assign stalled      = !i_empty && !i_pop;

    `NPES_CHECK_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, i_empty)
    `NPES_CHECK_NOW(a_status_last, i_clk, !i_rst_n, is_status, status_clear)
    `NPES_CHECK_NOW(a_read_aligned, i_clk, !i_rst_n, is_read, read_clean)
    `NPES_CHECK_NEXT(a_stall_hold, i_clk, !i_rst_n, stalled, !i_empty && $stable(i_out_item))

endmodule

bind nor_program_erase_sequencer_core npes_checker u_npes_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_pop      (pop),
    .i_empty    (empty),
    .i_out_item (o_out_item)
);
